// ===== rtl/has_pkg.sv =====
package has_pkg;

    localparam int HAS_HASH_BITS = 16;
    localparam int HAS_WAYS      = 4;
    localparam int HAS_QDEPTH    = 2;
    localparam int ADDR_W        = 64;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REWIND = 2'd1;
    localparam t_cmd CMD_READ   = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_NEW     = 2'd0;
    localparam t_status ST_PRESENT = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_DONE    = 2'd3;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr_out;
        logic              addr_valid;
    } t_result;

    function automatic logic [15:0] fold16(input logic [ADDR_W-1:0] a);
        return a[15:0] ^ a[31:16] ^ a[47:32] ^ a[63:48];
    endfunction

endpackage

// ===== rtl/hashed_address_set.sv =====
// channel   | direction | beat taken when       | payload
// ----------+-----------+-----------------------+---------------------------------
// command   | in        | push & !full          | i_item   (cmd, address)
// result    | out       | pop & !empty          | o_result (status, addr_out, addr_valid)
//
// After reset the fill counts are swept to zero, one bucket a cycle, with full held high
// throughout. A two-beat command queue decouples intake from execution. An insert reads
// its bucket's fill count, then compares the entries in turn; rewind probes the fill
// counts from bucket 0 on, a read-next that leaves a bucket those of the later buckets;
// read-next past the end and the unused command are answered straight from idle.
// One result beat per command; the next command waits in the queue until the previous result is taken.
module hashed_address_set #(
    parameter int HASH_BITS = has_pkg::HAS_HASH_BITS,
    parameter int WAYS      = has_pkg::HAS_WAYS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  has_pkg::t_item    i_item,
    output logic              empty,
    input  logic              pop,
    output has_pkg::t_result  o_result
);
    import has_pkg::*;

    logic                  q_full;
    logic                  clearing;
    logic                  job_vld;
    logic                  job_take;
    t_item                 job;
    logic [HASH_BITS-1:0]  job_bucket;

    assign full = q_full || clearing;

    has_front #(
        .HASH_BITS (HASH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push && !full),
        .i_item       (i_item),
        .o_q_full     (q_full),
        .o_job_vld    (job_vld),
        .o_job        (job),
        .o_job_bucket (job_bucket),
        .i_job_take   (job_take)
    );

    has_back #(
        .HASH_BITS (HASH_BITS),
        .WAYS      (WAYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_vld    (job_vld),
        .i_job        (job),
        .i_job_bucket (job_bucket),
        .o_job_take   (job_take),
        .o_clearing   (clearing),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

`ifndef SYNTH
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (full && empty && !job_take))
        else $error("activity during fill clear");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty)
        else $error("result beat followed by another without a command");

    a_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take |-> (empty && job_vld))
        else $error("command started while a result waits");
`endif

endmodule

// ===== rtl/has_front.sv =====
module has_front #(
    parameter int HASH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  has_pkg::t_item        i_item,
    output logic                  o_q_full,
    output logic                  o_job_vld,
    output has_pkg::t_item        o_job,
    output logic [HASH_BITS-1:0]  o_job_bucket,
    input  logic                  i_job_take
);
    import has_pkg::*;

    localparam int QPTR_W = (HAS_QDEPTH > 1) ? $clog2(HAS_QDEPTH) : 1;
    localparam int QCNT_W = $clog2(HAS_QDEPTH + 1);

    t_item                 r_q_item [HAS_QDEPTH];
    logic [HASH_BITS-1:0]  r_q_bkt  [HAS_QDEPTH];
    logic [QPTR_W-1:0]     r_wp, r_rp, n_wp, n_rp;
    logic [QCNT_W-1:0]     r_cnt, n_cnt;
    logic [15:0]           folded;
    logic                  do_push, do_pop;

    assign folded   = fold16(i_item.address);
    assign o_q_full = (r_cnt == QCNT_W'(HAS_QDEPTH));
    assign do_push  = i_push && !o_q_full;
    assign o_job_vld = (r_cnt != '0);
    assign do_pop   = i_job_take && o_job_vld;
    assign o_job        = r_q_item[r_rp];
    assign o_job_bucket = r_q_bkt[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QPTR_W'(HAS_QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QPTR_W'(HAS_QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q_item[r_wp] <= i_item;
            r_q_bkt[r_wp]  <= folded[HASH_BITS-1:0];
        end
    end

endmodule

// ===== rtl/has_back.sv =====
module has_back #(
    parameter int HASH_BITS = 16,
    parameter int WAYS      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_vld,
    input  has_pkg::t_item        i_job,
    input  logic [HASH_BITS-1:0]  i_job_bucket,
    output logic                  o_job_take,
    output logic                  o_clearing,
    output logic                  o_empty,
    input  logic                  i_pop,
    output has_pkg::t_result      o_result
);
    import has_pkg::*;

    localparam int NB     = 1 << HASH_BITS;
    localparam int IB_W   = HASH_BITS + 1;
    localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int EA_W   = (NB * WAYS > 1) ? $clog2(NB * WAYS) : 1;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_INS_FILL = 6'b000100,
        S_INS_CMP  = 6'b001000,
        S_RD_WAIT  = 6'b010000,
        S_SEEK     = 6'b100000
    } t_state;

    function automatic logic [EA_W-1:0] ent_addr(input logic [HASH_BITS-1:0] b,
                                                 input logic [SLOT_W-1:0] s);
        return EA_W'(EA_W'(b) * EA_W'(WAYS)) + EA_W'(s);
    endfunction

    logic [FILL_W-1:0]     fill_mem [NB];
    logic [ADDR_W-1:0]     ent_mem  [NB * WAYS];

    t_state                r_state, n_state;
    logic [HASH_BITS-1:0]  r_clr, n_clr;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [HASH_BITS-1:0]  r_bucket, n_bucket;
    logic [FILL_W-1:0]     r_n, n_n;
    logic [SLOT_W-1:0]     r_scan, n_scan;
    logic [IB_W-1:0]       r_it_bucket, n_it_bucket;
    logic [SLOT_W-1:0]     r_it_slot, n_it_slot;
    logic [IB_W-1:0]       r_seek, n_seek;
    logic [HASH_BITS-1:0]  r_probe, n_probe;
    logic                  r_probe_vld, n_probe_vld;
    t_result               r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    logic [FILL_W-1:0]     r_fill_rd;
    logic [ADDR_W-1:0]     r_ent_rd;

    logic                  fill_we, ent_we;
    logic [HASH_BITS-1:0]  fill_waddr, fill_raddr;
    logic [FILL_W-1:0]     fill_wdata;
    logic [EA_W-1:0]       ent_waddr, ent_raddr;
    logic [FILL_W-1:0]     scan_nxt, it_nxt;

    assign scan_nxt   = FILL_W'(r_scan) + FILL_W'(1);
    assign it_nxt     = FILL_W'(r_it_slot) + FILL_W'(1);
    assign o_clearing = (r_state == S_CLEAR);
    assign o_empty    = !r_out_vld;
    assign o_result   = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_bucket    = r_bucket;
        n_n         = r_n;
        n_scan      = r_scan;
        n_it_bucket = r_it_bucket;
        n_it_slot   = r_it_slot;
        n_seek      = r_seek;
        n_probe     = r_probe;
        n_probe_vld = r_probe_vld;
        n_out       = r_out;
        n_out_vld   = r_out_vld;
        fill_raddr  = r_it_bucket[HASH_BITS-1:0];
        ent_raddr   = ent_addr(r_it_bucket[HASH_BITS-1:0], r_it_slot);
        fill_we     = 1'b0;
        fill_waddr  = r_bucket;
        fill_wdata  = r_n + FILL_W'(1);
        ent_we      = 1'b0;
        ent_waddr   = ent_addr(r_bucket, SLOT_W'(r_n));
        o_job_take  = 1'b0;

        if (i_pop && r_out_vld) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
                n_clr      = r_clr + HASH_BITS'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_job_vld && !r_out_vld) begin
                    o_job_take = 1'b1;
                    n_addr     = i_job.address;
                    n_bucket   = i_job_bucket;
                    n_out      = '{status: ST_DONE, addr_out: '0, addr_valid: 1'b0};
                    case (i_job.cmd)
                        CMD_INSERT: begin
                            fill_raddr = i_job_bucket;
                            n_state    = S_INS_FILL;
                        end
                        CMD_REWIND: begin
                            n_it_slot   = '0;
                            n_seek      = '0;
                            n_probe_vld = 1'b0;
                            n_state     = S_SEEK;
                        end
                        CMD_READ: begin
                            if (r_it_bucket[HASH_BITS]) begin
                                n_out_vld = 1'b1;
                            end else begin
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_FILL: begin
                n_n    = r_fill_rd;
                n_scan = '0;
                if (r_fill_rd == '0) begin
                    fill_we      = 1'b1;
                    fill_wdata   = FILL_W'(1);
                    ent_we       = 1'b1;
                    ent_waddr    = ent_addr(r_bucket, '0);
                    n_out.status = ST_NEW;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    ent_raddr = ent_addr(r_bucket, '0);
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (r_ent_rd == r_addr) begin
                    n_out.status = ST_PRESENT;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end else if (scan_nxt == r_n) begin
                    if (r_n == FILL_W'(WAYS)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        fill_we      = 1'b1;
                        ent_we       = 1'b1;
                        n_out.status = ST_NEW;
                    end
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_scan    = SLOT_W'(scan_nxt);
                    ent_raddr = ent_addr(r_bucket, SLOT_W'(scan_nxt));
                end
            end
            S_RD_WAIT: begin
                if (FILL_W'(r_it_slot) < r_fill_rd) begin
                    n_out.addr_out   = r_ent_rd;
                    n_out.addr_valid = 1'b1;
                end
                if (it_nxt >= r_fill_rd) begin
                    n_it_slot   = '0;
                    n_seek      = r_it_bucket + IB_W'(1);
                    n_probe_vld = 1'b0;
                    n_state     = S_SEEK;
                end else begin
                    n_it_slot = SLOT_W'(it_nxt);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SEEK: begin
                fill_raddr = r_seek[HASH_BITS-1:0];
                if (r_probe_vld && (r_fill_rd != '0)) begin
                    n_it_bucket = {1'b0, r_probe};
                    n_out_vld   = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_seek[HASH_BITS]) begin
                    n_it_bucket = IB_W'(NB);
                    n_out_vld   = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_probe     = r_seek[HASH_BITS-1:0];
                    n_probe_vld = 1'b1;
                    n_seek      = r_seek + IB_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_it_bucket <= IB_W'(NB);
            r_it_slot   <= '0;
            r_probe_vld <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_it_bucket <= n_it_bucket;
            r_it_slot   <= n_it_slot;
            r_probe_vld <= n_probe_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_bucket <= n_bucket;
        r_n      <= n_n;
        r_scan   <= n_scan;
        r_seek   <= n_seek;
        r_probe  <= n_probe;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_rd <= fill_mem[fill_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= r_addr;
        end
        r_ent_rd <= ent_mem[ent_raddr];
    end

endmodule
